// ----- rtl/depth_pixel_backprojection_core_defines.svh -----
// Assertion macros shared by the depth pixel back-projection RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("depth pixel back-projection: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DPB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("depth pixel back-projection: next-cycle check failed");

`endif

// ----- rtl/dpb_pkg.sv -----
// Shared widths, codes and pipeline control type for depth pixel back-projection.
// No dependencies.
package dpb_pkg;

    localparam int DEPTH_W    = 16;
    localparam int DIST_W     = 31;
    localparam int CENTER_W   = 16;
    localparam int INVF_W     = 24;
    localparam int XY_W       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [DEPTH_W-1:0] DEPTH_INVALID = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_NEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_FAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_U    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_V    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_U = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_V = 3'd5;

    localparam logic [DIST_W-1:0] CLIP_FAR_RESET = 31'd65536;
    localparam logic [DIST_W-1:0] DIST_MAX       = 31'h7FFF_FFFF;

    // Pipeline stages: input, multiply, three divide steps, z, lateral product, output.
    localparam int NUM_STG = 8;
    localparam int ST_IN   = 0;
    localparam int ST_Z    = 5;
    localparam int ST_OUT  = 7;

    typedef struct packed {
        logic [NUM_STG-1:0] load;
        logic [NUM_STG-1:0] valid;
    } dpb_pipe_ctrl_t;

endpackage

// ----- rtl/dpb_zmap.sv -----
// Depth code to z mapping pipeline: span multiply, division by 65535, clip.
// Depends on dpb_pkg; stage loads come from the top-level pipeline control.
module dpb_zmap import dpb_pkg::*; (
    input  logic                 aclk,
    input  dpb_pipe_ctrl_t       ctrl,
    input  logic [DEPTH_W-1:0]   depth_code,
    input  logic [DIST_W-1:0]    clip_near,
    input  logic [DIST_W-1:0]    clip_far,
    output logic [DIST_W-1:0]    z_mid,
    output logic [DIST_W-1:0]    z_out
);

    localparam int PROD_W = DIST_W + DEPTH_W;

    logic [DEPTH_W-1:0] d_reg;
    logic [DIST_W-1:0]  span_reg, span_next;
    logic [4:0]         down_reg;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DIST_W-1:0]  q0_reg, q0_next;
    logic [DIST_W:0]    s1_reg, s1_next;
    logic [DIST_W-1:0]  qa_reg, qa_next;
    logic [16:0]        s2_reg, s2_next;
    logic [DIST_W-1:0]  q_reg, q_next;
    logic [DIST_W-1:0]  z5_reg, z5_next;
    logic [DIST_W-1:0]  z6_reg, z7_reg;

    logic [PROD_W-1:0]  n_sum;
    logic [16:0]        s3;
    logic               s3_carry;
    logic [DIST_W:0]    near_sum;

    always_comb begin
        span_next = (clip_far < clip_near) ? (clip_near - clip_far) : (clip_far - clip_near);
        prod_next = PROD_W'(span_reg) * PROD_W'(d_reg);

        // N = 65536*q0 + r0 = 65535*q0 + (q0 + r0); the same split is applied twice more.
        n_sum   = prod_reg + PROD_W'(32767);
        q0_next = n_sum[PROD_W-1:16];
        s1_next = (DIST_W+1)'(n_sum[PROD_W-1:16]) + (DIST_W+1)'(n_sum[15:0]);

        s2_next = 17'(s1_reg[DIST_W:16]) + 17'(s1_reg[15:0]);
        qa_next = q0_reg + DIST_W'(s1_reg[DIST_W:16]);

        s3       = 17'(s2_reg[15:0]) + 17'(s2_reg[16]);
        s3_carry = (s3 >= 17'd65535);
        q_next   = qa_reg + DIST_W'(s2_reg[16]) + DIST_W'(s3_carry);

        near_sum = (DIST_W+1)'(clip_near) + (DIST_W+1)'(q_reg);
        if (down_reg[4]) begin
            z5_next = (q_reg > clip_near) ? '0 : (clip_near - q_reg);
        end else begin
            z5_next = near_sum[DIST_W] ? DIST_MAX : near_sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            d_reg       <= depth_code;
            span_reg    <= span_next;
            down_reg[0] <= (clip_far < clip_near);
        end
        if (ctrl.load[1]) begin
            prod_reg    <= prod_next;
            down_reg[1] <= down_reg[0];
        end
        if (ctrl.load[2]) begin
            q0_reg      <= q0_next;
            s1_reg      <= s1_next;
            down_reg[2] <= down_reg[1];
        end
        if (ctrl.load[3]) begin
            qa_reg      <= qa_next;
            s2_reg      <= s2_next;
            down_reg[3] <= down_reg[2];
        end
        if (ctrl.load[4]) begin
            q_reg       <= q_next;
            down_reg[4] <= down_reg[3];
        end
        if (ctrl.load[5]) begin
            z5_reg <= z5_next;
        end
        if (ctrl.load[6]) begin
            z6_reg <= z5_reg;
        end
        if (ctrl.load[7]) begin
            z7_reg <= z6_reg;
        end
    end

    assign z_mid = z5_reg;
    assign z_out = z7_reg;

endmodule

// ----- rtl/dpb_lateral.sv -----
// One lateral coordinate pipeline: pixel offset, slope, scale by z, round and saturate.
// Depends on dpb_pkg and the assertion macro header; z arrives from dpb_zmap.
`include "depth_pixel_backprojection_core_defines.svh"

module dpb_lateral import dpb_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dpb_pipe_ctrl_t        ctrl,
    input  logic [COORD_BITS-1:0] coord,
    input  logic [CENTER_W-1:0]   center,
    input  logic [INVF_W-1:0]     inv_focal,
    input  logic [DIST_W-1:0]     z,
    output logic [XY_W-1:0]       point
);

    localparam int CQ_W = COORD_BITS + 4;
    localparam int DW   = (CQ_W > CENTER_W) ? CQ_W : CENTER_W;
    localparam int PT_W = DW + INVF_W;
    localparam int TW   = PT_W - 12;
    localparam int PP_W = DIST_W + TW;
    localparam int PR_W = PP_W - 16;

    logic [DW-1:0]      cq, cen, dmag_next;
    logic               neg_next;
    logic [NUM_STG-1:0] neg_reg;
    logic [DW-1:0]      dmag_reg;
    logic [PT_W-1:0]    pt_reg, pt_next, t_sum;
    logic [TW-1:0]      tmag_reg [2:ST_Z];
    logic [PP_W-1:0]    p_reg, p_next, p_sum;
    logic [PR_W-1:0]    pmag;
    logic [XY_W-1:0]    mag32;
    logic [XY_W-1:0]    point_reg, point_next;

    always_comb begin
        cq        = DW'({coord, 4'b0000});
        cen       = DW'(center);
        neg_next  = (cq < cen);
        dmag_next = neg_next ? (cen - cq) : (cq - cen);

        pt_next = PT_W'(dmag_reg) * PT_W'(inv_focal);
        t_sum   = pt_reg + PT_W'(2048);

        p_next = PP_W'(z) * PP_W'(tmag_reg[ST_Z]);

        // Round the magnitude half up, then saturate asymmetrically by sign.
        p_sum = p_reg + PP_W'(32768);
        pmag  = p_sum[PP_W-1:16];
        if (neg_reg[ST_OUT-1]) begin
            mag32      = (pmag > PR_W'(33'h0_8000_0000)) ? 32'h8000_0000 : pmag[XY_W-1:0];
            point_next = 32'd0 - mag32;
        end else begin
            mag32      = (pmag > PR_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : pmag[XY_W-1:0];
            point_next = mag32;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_STG; k++) begin
            if (ctrl.load[k]) begin
                neg_reg[k] <= (k == 0) ? neg_next : neg_reg[(k == 0) ? 0 : k-1];
            end
        end
        if (ctrl.load[0]) begin
            dmag_reg <= dmag_next;
        end
        if (ctrl.load[1]) begin
            pt_reg <= pt_next;
        end
        if (ctrl.load[2]) begin
            tmag_reg[2] <= t_sum[PT_W-1:12];
        end
        for (int k = 3; k <= ST_Z; k++) begin
            if (ctrl.load[k]) begin
                tmag_reg[k] <= tmag_reg[k-1];
            end
        end
        if (ctrl.load[6]) begin
            p_reg <= p_next;
        end
        if (ctrl.load[7]) begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

    // A pixel left of (or above) the principal point never yields a positive coordinate.
    `DPB_ASSERT_SAME(a_lat_sign, ctrl.valid[ST_OUT], neg_reg[ST_OUT] ? (point[XY_W-1] || point == '0) : !point[XY_W-1])

endmodule

// ----- rtl/depth_pixel_backprojection_core.sv -----
// Depth pixel back-projection: depth pixel in, camera-frame point out.
// The stream side carries {depth_code, pixel_col, pixel_row} in, {point_z, point_y, point_x} out.
// Channels: s_ carries one depth pixel per word, m_ one point per word; both
// transfer when tvalid and tready are high at the rising edge of aclk.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at the clock
// edge (0 clip_near, 1 clip_far, 2 center_u, 3 center_v, 4 inv_focal_u,
// 5 inv_focal_v); other indexes are ignored. Write only while no pixel is in
// flight.
// Throughput: one pixel per cycle while the receiver does not stall, set by
// the eight-stage pipeline in which every stage holds one pixel; the z and
// lateral multipliers sit in separate stages.
// Pixels with depth code 65535 are taken and produce no point.
// When the receiver stalls, each stage holds its word and bubbles upstream
// close up, so s_tready stays high until every stage is full.
// Reset (aresetn low, synchronous) empties the pipeline and returns the
// configuration registers to their reset values.
// Depends on dpb_pkg, dpb_zmap, dpb_lateral and the assertion macro header.
`include "depth_pixel_backprojection_core_defines.svh"

module depth_pixel_backprojection_core import dpb_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Lowest bit up: pixel_row, pixel_col, depth_code, zero fill.
    input  logic [((2*COORD_BITS+DEPTH_W+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Lowest bit up: point_x, point_y, point_z, zero fill.
    output logic [((2*XY_W+DIST_W+7)/8)*8-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int M_DATA_W = ((2*XY_W+DIST_W+7)/8)*8;

    logic [DIST_W-1:0]   clip_near_reg, clip_far_reg;
    logic [CENTER_W-1:0] center_u_reg, center_v_reg;
    logic [INVF_W-1:0]   inv_focal_u_reg, inv_focal_v_reg;

    logic [COORD_BITS-1:0] pixel_row, pixel_col;
    logic [DEPTH_W-1:0]    depth_code;

    logic [NUM_STG-1:0] vld_reg, vld_next;
    logic [NUM_STG-1:0] adv;
    dpb_pipe_ctrl_t     ctrl;

    logic [DIST_W-1:0] z_mid, z_out;
    logic [XY_W-1:0]   point_x, point_y;

    assign pixel_row  = s_tdata[COORD_BITS-1:0];
    assign pixel_col  = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign depth_code = s_tdata[2*COORD_BITS+DEPTH_W-1:2*COORD_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_near_reg   <= '0;
            clip_far_reg    <= CLIP_FAR_RESET;
            center_u_reg    <= '0;
            center_v_reg    <= '0;
            inv_focal_u_reg <= '0;
            inv_focal_v_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_CLIP_NEAR:   clip_near_reg   <= cfg_wdata[DIST_W-1:0];
                CFG_CLIP_FAR:    clip_far_reg    <= cfg_wdata[DIST_W-1:0];
                CFG_CENTER_U:    center_u_reg    <= cfg_wdata[CENTER_W-1:0];
                CFG_CENTER_V:    center_v_reg    <= cfg_wdata[CENTER_W-1:0];
                CFG_INV_FOCAL_U: inv_focal_u_reg <= cfg_wdata[INVF_W-1:0];
                CFG_INV_FOCAL_V: inv_focal_v_reg <= cfg_wdata[INVF_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its word moves on in the same cycle.
    always_comb begin
        adv[NUM_STG-1] = !vld_reg[NUM_STG-1] || m_tready;
        for (int k = NUM_STG-2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = vld_reg;
        for (int k = 0; k < NUM_STG; k++) begin
            if (adv[k]) begin
                vld_next[k] = (k == 0) ? (s_tvalid && (depth_code != DEPTH_INVALID))
                                       : vld_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign ctrl     = {adv, vld_reg};
    assign s_tready = adv[ST_IN];
    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = M_DATA_W'({z_out, point_y, point_x});

    dpb_zmap u_zmap (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .depth_code (depth_code),
        .clip_near  (clip_near_reg),
        .clip_far   (clip_far_reg),
        .z_mid      (z_mid),
        .z_out      (z_out)
    );

    dpb_lateral #(.COORD_BITS(COORD_BITS)) u_lat_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .coord     (pixel_col),
        .center    (center_u_reg),
        .inv_focal (inv_focal_u_reg),
        .z         (z_mid),
        .point     (point_x)
    );

    dpb_lateral #(.COORD_BITS(COORD_BITS)) u_lat_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .coord     (pixel_row),
        .center    (center_v_reg),
        .inv_focal (inv_focal_v_reg),
        .z         (z_mid),
        .point     (point_y)
    );

    // A no-return pixel is taken but never enters the pipeline as a word.
    `DPB_ASSERT_NEXT(a_invalid_drop, s_tvalid && s_tready && (depth_code == DEPTH_INVALID), !vld_reg[ST_IN])
    // A stalled middle stage keeps its word.
    `DPB_ASSERT_NEXT(a_mid_hold, vld_reg[3] && !adv[3], vld_reg[3])
    // Taking the last word with nothing behind it leaves the output empty.
    `DPB_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !vld_reg[ST_OUT-1], !m_tvalid)

endmodule
